FILE: rtl/core/tpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ID_BITS     = 16;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int PRIO_W = 4;
	localparam int RUNS_W = 7;
	// common width for comparing stored ids against the 16-bit request id
	localparam int CMP_W  = (ID_BITS > 16) ? ID_BITS : 16;

	localparam logic [PRIO_W-1:0] MAX_PRIO = PRIO_W'(9);
	localparam logic [RUNS_W-1:0] MAX_RUNS = RUNS_W'(99);

	localparam logic [2:0] KIND_INSERT   = 3'd0;
	localparam logic [2:0] KIND_RUN_HEAD = 3'd1;
	localparam logic [2:0] KIND_RUN_ID   = 3'd2;
	localparam logic [2:0] KIND_DELETE   = 3'd3;
	localparam logic [2:0] KIND_SET_PRIO = 3'd4;
	localparam logic [2:0] KIND_TOGGLE   = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [PRIO_W-1:0]  prio;
		logic [RUNS_W-1:0]  runs;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/core/tpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/core/two_policy_task_queue_unit.sv
// Task table with two head policies.
// Slave stream: s_tuser carries the operation kind, s_tdata the task id,
// requested priority and run count. Master stream: one result per
// operation in m_tdata (status, acted id, runs left, finished flag, task
// count, current policy).
// Insert, toggle and unknown kinds, and any operation on an empty table,
// finish without a sweep (insert writes its entry straight into the table memory).
// Run head, run by id, delete and set priority sweep the table memory one
// entry per cycle through its single read port, then write back the chosen
// entry where it changes: a run that does not finish, or set priority.
// The block holds one operation at a time; s_tready is high only when idle.
// The result sits in an output register; a new operation is taken while it
// waits, but that operation cannot deliver until the receiver takes the
// older result, so a stalled receiver stalls the block after one operation.
// Reset empties the table, sets the policy to highest priority first and
// the next id to one. The table memory itself is not cleared; per-slot
// valid flops mark which entries hold tasks.
`timescale 1ns / 1ps
`default_nettype none

module two_policy_task_queue_unit
	import tpq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // task_id[15:0], priority_req[19:16], runs[26:20]
	input  wire logic [2:0]  s_tuser,   // kind[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata    // status[1:0], acted_id[17:2], runs_left[24:18],
	                                    // finished[25], task_count[30:26], policy_now[31]
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_OUT
	} state_t;

	state_t state_q;

	logic [TABLE_DEPTH-1:0] slot_valid_q;
	logic [CNT_W-1:0]       live_q;
	logic [ID_BITS-1:0]     next_id_q;
	logic                   policy_q;

	logic [2:0]        kind_q;
	logic [15:0]       tid_q;
	logic [PRIO_W-1:0] prio_q;

	logic [CNT_W-1:0] scan_cnt_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_q;

	logic [1:0]  res_status_q;
	logic [15:0] res_acted_q;
	logic [6:0]  res_left_q;
	logic        res_fin_q;

	// input fields
	logic [2:0]        in_kind;
	logic [15:0]       in_tid;
	logic [PRIO_W-1:0] in_prio_raw, in_prio;
	logic [RUNS_W-1:0] in_runs_raw, in_runs;
	logic              in_fire;

	assign in_kind     = s_tuser;
	assign in_tid      = s_tdata[15:0];
	assign in_prio_raw = s_tdata[19:16];
	assign in_runs_raw = s_tdata[26:20];
	assign in_prio     = (in_prio_raw > MAX_PRIO) ? MAX_PRIO : in_prio_raw;
	assign in_runs     = (in_runs_raw == '0) ? RUNS_W'(1) :
	                     (in_runs_raw > MAX_RUNS) ? MAX_RUNS : in_runs_raw;

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// lowest free slot
	logic [IDX_W-1:0] free_idx;
	always_comb begin
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	logic table_full;
	assign table_full = (live_q >= CNT_W'(TABLE_DEPTH));

	// table memory
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;
	logic [ENTRY_W-1:0] ram_rdata_raw;

	tpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(scan_cnt_q[IDX_W-1:0]),
		.rdata(ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	// candidate selection during the sweep
	logic cand_ok, id_match, ahead, take;
	always_comb begin
		cand_ok  = rd_valid_s1 && slot_valid_q[rd_idx_s1];
		id_match = (CMP_W'(ram_rdata.id) == CMP_W'(tid_q));
		if (!policy_q) begin
			if (ram_rdata.prio != best_q.prio) begin
				ahead = ram_rdata.prio > best_q.prio;
			end else begin
				ahead = ram_rdata.id > best_q.id;
			end
		end else begin
			if (ram_rdata.runs != best_q.runs) begin
				ahead = ram_rdata.runs < best_q.runs;
			end else begin
				ahead = ram_rdata.id > best_q.id;
			end
		end
		if (kind_q == KIND_RUN_HEAD) begin
			take = cand_ok && (!found_q || ahead);
		end else begin
			take = cand_ok && !found_q && id_match;
		end
	end

	// write-back of the chosen entry
	logic [RUNS_W-1:0] runs_dec;
	logic              is_run;
	assign runs_dec = (best_q.runs == '0) ? '0 : best_q.runs - RUNS_W'(1);
	assign is_run   = (kind_q == KIND_RUN_HEAD) || (kind_q == KIND_RUN_ID);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = best_q;
		if (state_q == S_IDLE && in_fire && in_kind == KIND_INSERT && !table_full) begin
			ram_we         = 1'b1;
			ram_waddr      = free_idx;
			ram_wdata.id   = next_id_q;
			ram_wdata.prio = in_prio;
			ram_wdata.runs = in_runs;
		end else if (state_q == S_APPLY && found_q) begin
			if (is_run && runs_dec != '0) begin
				ram_we         = 1'b1;
				ram_wdata.runs = runs_dec;
			end else if (kind_q == KIND_SET_PRIO) begin
				ram_we         = 1'b1;
				ram_wdata.prio = prio_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			live_q       <= '0;
			next_id_q    <= ID_BITS'(1);
			policy_q     <= 1'b0;
			kind_q       <= KIND_TOGGLE;
			tid_q        <= '0;
			prio_q       <= '0;
			scan_cnt_q   <= '0;
			rd_valid_s1  <= 1'b0;
			rd_idx_s1    <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_q       <= '0;
			res_status_q <= ST_OK;
			res_acted_q  <= '0;
			res_left_q   <= '0;
			res_fin_q    <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
		end else begin
			// in S_OUT the result register is reloaded below instead
			if (m_tvalid && m_tready && state_q != S_OUT) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						kind_q       <= in_kind;
						tid_q        <= in_tid;
						prio_q       <= in_prio;
						res_status_q <= ST_OK;
						res_acted_q  <= '0;
						res_left_q   <= '0;
						res_fin_q    <= 1'b0;
						state_q      <= S_OUT;
						unique case (in_kind) inside
							KIND_INSERT: begin
								if (table_full) begin
									res_status_q <= ST_FULL;
								end else begin
									slot_valid_q[free_idx] <= 1'b1;
									live_q                 <= live_q + CNT_W'(1);
									res_acted_q            <= 16'(next_id_q);
									res_left_q             <= 7'(in_runs);
									next_id_q <= (next_id_q == '1) ? ID_BITS'(1) :
									             next_id_q + ID_BITS'(1);
								end
							end
							KIND_RUN_HEAD, KIND_RUN_ID, KIND_DELETE, KIND_SET_PRIO: begin
								if (live_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									scan_cnt_q  <= '0;
									rd_valid_s1 <= 1'b0;
									found_q     <= 1'b0;
									state_q     <= S_SCAN;
								end
							end
							KIND_TOGGLE: begin
								policy_q <= ~policy_q;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					// the compare trails the read issue by the RAM output register
					if (scan_cnt_q < CNT_W'(TABLE_DEPTH)) begin
						scan_cnt_q  <= scan_cnt_q + CNT_W'(1);
						rd_valid_s1 <= 1'b1;
						rd_idx_s1   <= scan_cnt_q[IDX_W-1:0];
					end else begin
						rd_valid_s1 <= 1'b0;
						if (!rd_valid_s1) begin
							state_q <= S_APPLY;
						end
					end
					if (take) begin
						found_q    <= 1'b1;
						best_idx_q <= rd_idx_s1;
						best_q     <= ram_rdata;
					end
				end
				S_APPLY: begin
					state_q <= S_OUT;
					if (!found_q) begin
						res_status_q <= (kind_q == KIND_RUN_HEAD) ? ST_EMPTY : ST_NOT_FOUND;
					end else begin
						res_acted_q <= 16'(best_q.id);
						if (is_run) begin
							res_left_q <= 7'(runs_dec);
							if (runs_dec == '0) begin
								slot_valid_q[best_idx_q] <= 1'b0;
								live_q                   <= live_q - CNT_W'(1);
								res_fin_q                <= 1'b1;
							end
						end else if (kind_q == KIND_DELETE) begin
							slot_valid_q[best_idx_q] <= 1'b0;
							live_q                   <= live_q - CNT_W'(1);
						end else begin
							res_left_q <= 7'(best_q.runs);
						end
					end
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {policy_q, 5'(live_q), res_fin_q, res_left_q,
						             res_acted_q, res_status_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// task count always matches the occupied slots
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		live_q == CNT_W'($countones(slot_valid_q)))
		else $error("task count out of step with slot flags");

	// id zero is never handed out
	a_next_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q != '0)
		else $error("next id reached zero");

	// a chosen slot is still occupied when it is written back
	a_apply_valid_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && found_q) |-> slot_valid_q[best_idx_q])
		else $error("write-back targets an empty slot");

	// a finishing run always reports success
	a_finish_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[25]) |-> (m_tdata[1:0] == ST_OK))
		else $error("finished flag with error status");

	// an insert never lands in an occupied slot
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_kind == KIND_INSERT && !table_full) |-> !slot_valid_q[free_idx])
		else $error("insert into occupied slot");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tpq_pkg::*;

	localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
	localparam logic [2:0] KIND_UNUSED_7 = 3'd7;
	localparam logic       POLICY_PRIO   = 1'b0;
	localparam logic       POLICY_RUNS   = 1'b1;

	// m_tdata layout, lowest field last
	typedef struct packed {
		logic       policy;
		logic [4:0] count;
		logic       fin;
		logic [6:0] left;
		logic [15:0] acted;
		logic [1:0] status;
	} outcome_t;

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic [4:0]  pad;
		logic [6:0]  runs;
		logic [3:0]  prio;
		logic [15:0] tid;
	} command_t;

	class task_table_tracker;
		bit                 live    [TABLE_DEPTH];
		logic [ID_BITS-1:0] tid_of  [TABLE_DEPTH];
		logic [3:0]         prio_of [TABLE_DEPTH];
		logic [6:0]         runs_of [TABLE_DEPTH];
		logic               policy;
		logic [ID_BITS-1:0] issue_id;
		int                 held;
		int                 errors;
		outcome_t           pending[$];

		function new();
			foreach (live[i]) live[i] = 1'b0;
			policy = POLICY_PRIO;
			issue_id = ID_BITS'(1);
			held = 0;
			errors = 0;
		endfunction

		function void log_command(logic [2:0] kind, logic [15:0] tid, logic [3:0] prio_in,
				logic [6:0] runs_in);
			outcome_t o;
			int s;
			bit better;
			logic [3:0] prio;
			logic [6:0] runs;
			o = '0;
			s = -1;
			better = 1'b0;
			prio = (prio_in > MAX_PRIO) ? MAX_PRIO : prio_in;
			runs = (runs_in == 0) ? 7'd1 : ((runs_in > MAX_RUNS) ? MAX_RUNS : runs_in);
			case (kind) inside
				KIND_INSERT: begin
					// lowest free slot
					for (int i = TABLE_DEPTH - 1; i >= 0; i--)
						if (!live[i]) s = i;
					if (held >= TABLE_DEPTH || s < 0) begin
						o.status = ST_FULL;
					end else begin
						live[s] = 1'b1;
						tid_of[s] = issue_id;
						prio_of[s] = prio;
						runs_of[s] = runs;
						held++;
						o.acted = issue_id;
						o.left = runs;
						issue_id = (issue_id == {ID_BITS{1'b1}}) ? ID_BITS'(1) :
							issue_id + ID_BITS'(1);
					end
				end
				KIND_RUN_HEAD, KIND_RUN_ID, KIND_DELETE, KIND_SET_PRIO: begin
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (!live[i]) continue;
						if (kind != KIND_RUN_HEAD) begin
							// duplicate ids: lowest slot wins
							if (s < 0 && tid_of[i] == tid) s = i;
						end else begin
							if (s < 0)
								better = 1'b1;
							else if (policy == POLICY_PRIO && prio_of[i] != prio_of[s])
								better = prio_of[i] > prio_of[s];
							else if (policy == POLICY_RUNS && runs_of[i] != runs_of[s])
								better = runs_of[i] < runs_of[s];
							else
								better = tid_of[i] > tid_of[s];
							if (better) s = i;
						end
					end
					if (held == 0) begin
						o.status = ST_EMPTY;
					end else if (s < 0) begin
						o.status = ST_NOT_FOUND;
					end else begin
						o.acted = tid_of[s];
						if (kind == KIND_RUN_HEAD || kind == KIND_RUN_ID) begin
							runs_of[s] = runs_of[s] - 7'd1;
							o.left = runs_of[s];
							if (runs_of[s] == 0) begin
								live[s] = 1'b0;
								held--;
								o.fin = 1'b1;
							end
						end else if (kind == KIND_DELETE) begin
							live[s] = 1'b0;
							held--;
						end else begin
							prio_of[s] = prio;
							o.left = runs_of[s];
						end
					end
				end
				KIND_TOGGLE: policy = ~policy;
				default: ;
			endcase
			o.count = 5'(held);
			o.policy = policy;
			pending.push_back(o);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(logic [31:0] word);
			outcome_t got;
			outcome_t want;
			got = word;
			if (pending.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual %h", $time, word);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("acted_id", want.acted, got.acted);
			compare_field("runs_left", want.left, got.left);
			compare_field("finished", want.fin, got.fin);
			compare_field("task_count", want.count, got.count);
			compare_field("policy_now", want.policy, got.policy);
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	task_table_tracker tracker = new();

	two_policy_task_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// returns at the edge of the transfer with s_tvalid still high
	task automatic send_command(logic [2:0] kind, logic [15:0] tid, logic [3:0] prio,
			logic [6:0] runs);
		command_t c;
		c = '{pad: '0, runs: runs, prio: prio, tid: tid};
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.log_command(kind, tid, prio, runs);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending.size() != 0) @(posedge clk);
	endtask

	task automatic random_command();
		int pick;
		int n;
		logic [2:0] kind;
		logic [15:0] tid;
		logic [3:0] prio;
		logic [6:0] runs;
		pick = $urandom_range(99);
		if (pick < 32) kind = KIND_INSERT;
		else if (pick < 50) kind = KIND_RUN_HEAD;
		else if (pick < 64) kind = KIND_RUN_ID;
		else if (pick < 74) kind = KIND_DELETE;
		else if (pick < 86) kind = KIND_SET_PRIO;
		else if (pick < 94) kind = KIND_TOGGLE;
		else if (pick < 97) kind = KIND_UNUSED_6;
		else kind = KIND_UNUSED_7;
		tid = 16'($urandom_range(16'hFFFF));
		pick = $urandom_range(9);
		if (pick < 7 && tracker.held > 0) begin
			n = $urandom_range(tracker.held - 1);
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (tracker.live[i]) begin
					if (n == 0) tid = tracker.tid_of[i];
					n--;
				end
		end else if (pick < 9) begin
			// recently issued ids, mostly gone already
			tid = 16'(tracker.issue_id - ID_BITS'($urandom_range(8, 1)));
		end
		prio = ($urandom_range(9) < 8) ? 4'($urandom_range(9)) : 4'($urandom_range(15, 10));
		pick = $urandom_range(19);
		if (pick < 11) runs = 7'($urandom_range(4, 1));
		else if (pick < 17) runs = 7'($urandom_range(99, 1));
		else if (pick < 18) runs = 7'd0;
		else runs = 7'($urandom_range(127, 100));
		send_command(kind, tid, prio, runs);
	endtask

	// result side
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) tracker.check_outcome(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty table
		send_command(KIND_RUN_HEAD, 16'd0, 4'd0, 7'd1);
		send_command(KIND_RUN_ID, 16'd5, 4'd0, 7'd1);
		send_command(KIND_DELETE, 16'hFFFF, 4'd0, 7'd1);
		send_command(KIND_SET_PRIO, 16'd1, 4'd15, 7'd1);
		// fill up, priorities past 9 and runs out of range included
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_command(KIND_INSERT, 16'hA5A5, 4'(i),
				(i == 0) ? 7'd0 : ((i == 1) ? 7'd127 : 7'(i * 8)));
		send_command(KIND_INSERT, 16'd0, 4'd3, 7'd5);
		send_command(KIND_RUN_HEAD, 16'd0, 4'd0, 7'd1);
		send_command(KIND_TOGGLE, 16'd0, 4'd0, 7'd1);
		send_command(KIND_RUN_HEAD, 16'd0, 4'd0, 7'd1);
		send_command(KIND_RUN_ID, 16'hFFFF, 4'd0, 7'd1);
		send_command(KIND_DELETE, 16'd0, 4'd0, 7'd1);
		send_command(KIND_SET_PRIO, 16'd4, 4'd12, 7'd1);
		send_command(KIND_RUN_ID, 16'd5, 4'd0, 7'd1);
		send_command(KIND_DELETE, 16'd6, 4'd0, 7'd1);
		send_command(KIND_UNUSED_6, 16'd2, 4'd9, 7'd9);
		send_command(KIND_UNUSED_7, 16'd3, 4'd9, 7'd9);
		send_command(KIND_TOGGLE, 16'd0, 4'd0, 7'd1);

		// clear out everything but ids 2 and 3
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (tracker.live[i] && tracker.tid_of[i] > 3)
				send_command(KIND_DELETE, 16'(tracker.tid_of[i]), 4'd0, 7'd1);

		// refill a little, then act on the low ids
		send_command(KIND_INSERT, 16'd0, 4'd9, 7'd1);
		send_command(KIND_INSERT, 16'd0, 4'd1, 7'd99);
		send_command(KIND_INSERT, 16'd0, 4'd1, 7'd99);
		send_command(KIND_INSERT, 16'd0, 4'd2, 7'd16);
		send_command(KIND_RUN_HEAD, 16'd0, 4'd0, 7'd1);
		send_command(KIND_DELETE, 16'd3, 4'd0, 7'd1);
		send_command(KIND_DELETE, 16'd3, 4'd0, 7'd1);
		send_command(KIND_RUN_HEAD, 16'd0, 4'd0, 7'd1);
		send_command(KIND_SET_PRIO, 16'd2, 4'd5, 7'd1);
		send_command(KIND_RUN_ID, 16'd2, 4'd0, 7'd1);
		drain_results();

		repeat (125) random_command();
		drain_results();
		send_idle_pct = 72;
		repeat (125) random_command();
		drain_results();
		send_idle_pct = 0;
		recv_stall_pct = 72;
		repeat (125) random_command();
		drain_results();
		send_idle_pct = 11;
		recv_stall_pct = 11;
		repeat (125) random_command();
		drain_results();

		// stray results would show up here
		repeat (40) @(posedge clk);
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
